@@ sv/cpds_pkg.sv @@
// shared types, constants and saturation helpers for the capture point simulator
package cpds_pkg;

    localparam int FRAC_BITS = 16;

    // outcome codes
    localparam logic [2:0] OUT_CAPTURE   = 3'd0;
    localparam logic [2:0] OUT_OVERSHOOT = 3'd1;
    localparam logic [2:0] OUT_UNDERSHOOT = 3'd2;
    localparam logic [2:0] OUT_SLIP      = 3'd3;
    localparam logic [2:0] OUT_LIMIT     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_GRAVITY   = 3'd0;
    localparam logic [2:0] REG_FRICTION  = 3'd1;
    localparam logic [2:0] REG_POS_TOL   = 3'd2;
    localparam logic [2:0] REG_SPEED_TOL = 3'd3;
    localparam logic [2:0] REG_STEP_SIZE = 3'd4;

    // register reset values
    localparam logic [30:0] GRAVITY_RST   = 31'd642253;
    localparam logic [30:0] FRICTION_INF  = 31'h7FFF_FFFF;
    localparam logic [30:0] POS_TOL_RST   = 31'd328;
    localparam logic [30:0] SPEED_TOL_RST = 31'd655;
    localparam logic [30:0] STEP_SIZE_RST = 31'd655;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE, ST_CHECK, ST_SLOPE0_WAIT, ST_TOP, ST_BEND_MUL, ST_SLOPE,
        ST_DXS_MUL, ST_DENOM, ST_NXDX, ST_NYDY, ST_DNORM, ST_NXDY, ST_DTANG,
        ST_FRIC, ST_VXVX, ST_VV, ST_VVB, ST_TERM, ST_DXT, ST_AX_START,
        ST_AX_WAIT, ST_VSTEP, ST_PX, ST_REL, ST_RELSQ, ST_RR, ST_RS, ST_PY,
        ST_ASTEP, ST_VX, ST_VY_MUL, ST_VY, ST_FIN
    } state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // magnitude of a 33-bit signed value
    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        logic [32:0] r;
        r = (v < 0) ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

@@ sv/cpds_div.sv @@
// radix-2 restoring divider, signed 64 by 32, quotient truncated and saturated
module cpds_div
    import cpds_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [31:0] divisor,
    output logic signed [31:0] quot,
    output div_status_t        status
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_sh;

    // one quotient bit a cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[31:0], num_reg[63]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = (dividend < 0) ? 64'(-dividend) : 64'(dividend);
            den_next  = (divisor < 0) ? 32'(-divisor) : 32'(divisor);
            neg_next  = dividend[63] ^ divisor[31];
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = rem_sh - {1'b0, den_reg};
                num_next = {num_reg[62:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                num_next = {num_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // sign and saturation of the quotient
    always_comb begin
        if (neg_reg) begin
            if (num_reg > 64'h0000_0000_8000_0000) begin
                quot = 32'sh8000_0000;
            end else begin
                quot = -$signed(num_reg[31:0]);
            end
        end else begin
            if (num_reg > 64'h0000_0000_7FFF_FFFF) begin
                quot = 32'sh7FFF_FFFF;
            end else begin
                quot = $signed(num_reg[31:0]);
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ sv/capture_point_dynamics_sim.sv @@
// capture point simulator: sequencer around one shared multiplier and a divider
// flow: an immediate capture or a zero start speed goes straight to the result;
//   otherwise the divider forms the start slope, then each integration step runs the
//   sequencer, waits on the divider and may make the friction test, up to STEP_LIMIT
//   steps; the last step stops at its exit
// throughput: one item at a time, s_tready high again once the result is loaded
// reset: synchronous, active low; clears the sequencer and output valid and loads
//   the configuration registers with their defaults
module capture_point_dynamics_sim
    import cpds_pkg::*;
#(
    parameter int STEP_LIMIT = 1000
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [30:0]  cfg_wr_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_px, start_py, start_vx, start_vy, target_x, target_y,
    // surface_nx, surface_ny, path_bend, zero pad
    input  logic [287:0] s_tdata,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // outcome, end_px, end_py, end_vx, end_vy, steps_taken, zero pad
    output logic [143:0] m_tdata
);

    localparam int IW = $clog2(STEP_LIMIT + 1);

    state_t state_reg, state_next;

    // configuration
    logic [30:0] grav_reg, fric_reg, ptol_reg, stol_reg, step_reg;

    // item and working state
    logic signed [31:0] sx_reg, sy_reg, tx_reg, ty_reg, nx_reg, ny_reg, bend_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, slope0_reg;
    logic signed [31:0] dx_reg, dy_reg, t_reg, slope_reg, denom_reg;
    logic signed [31:0] dnorm_reg, dtang_reg, term_reg, ax_reg, u_reg, w_reg;
    logic [IW-1:0]      it_reg;
    logic [2:0]         outcome_reg;
    logic [IW-1:0]      steps_reg;

    // output register
    logic               m_valid_reg;
    logic [143:0]       m_data_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_sh;
    logic signed [31:0] fm;

    // divider
    logic               div_start;
    logic signed [63:0] div_dividend;
    logic signed [31:0] div_divisor;
    logic signed [31:0] div_quot;
    div_status_t        div_st;

    logic               accept, cap_now, out_free;
    logic [32:0]        pdist, vabs;
    logic signed [65:0] dt_abs;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign fm      = sat32(prod_sh[63:0]);

    // capture test on the current position and speed
    assign pdist   = abs33(33'(px_reg) - 33'(tx_reg));
    assign vabs    = abs33(33'(vx_reg));
    assign cap_now = (pdist < {2'b00, ptol_reg}) && (vabs < {2'b00, stol_reg});
    assign dt_abs  = $signed(66'(abs33(33'(dtang_reg))));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= GRAVITY_RST;
            fric_reg <= FRICTION_INF;
            ptol_reg <= POS_TOL_RST;
            stol_reg <= SPEED_TOL_RST;
            step_reg <= STEP_SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GRAVITY:   grav_reg <= cfg_wr_data;
                REG_FRICTION:  fric_reg <= cfg_wr_data;
                REG_POS_TOL:   ptol_reg <= cfg_wr_data;
                REG_SPEED_TOL: stol_reg <= cfg_wr_data;
                REG_STEP_SIZE: step_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (accept) state_next = ST_CHECK;
            ST_CHECK: begin
                if (cap_now || vx_reg == 0) state_next = ST_FIN;
                else state_next = ST_SLOPE0_WAIT;
            end
            ST_SLOPE0_WAIT: if (div_st.done) state_next = ST_TOP;
            ST_TOP:         state_next = (px_reg > tx_reg) ? ST_FIN : ST_BEND_MUL;
            ST_BEND_MUL:    state_next = ST_SLOPE;
            ST_SLOPE:       state_next = ST_DXS_MUL;
            ST_DXS_MUL:     state_next = ST_DENOM;
            ST_DENOM:       state_next = ST_NXDX;
            ST_NXDX:        state_next = (denom_reg == 0) ? ST_FIN : ST_NYDY;
            ST_NYDY:        state_next = ST_DNORM;
            ST_DNORM:       state_next = ST_NXDY;
            ST_NXDY:        state_next = ST_DTANG;
            ST_DTANG:       state_next = (fric_reg == FRICTION_INF) ? ST_VXVX : ST_FRIC;
            ST_FRIC:        state_next = (dt_abs > prod_sh) ? ST_FIN : ST_VXVX;
            ST_VXVX:        state_next = ST_VV;
            ST_VV:          state_next = ST_VVB;
            ST_VVB:         state_next = ST_TERM;
            ST_TERM:        state_next = ST_DXT;
            ST_DXT:         state_next = ST_AX_START;
            ST_AX_START:    state_next = ST_AX_WAIT;
            ST_AX_WAIT:     if (div_st.done) state_next = ST_VSTEP;
            ST_VSTEP:       state_next = ST_PX;
            ST_PX:          state_next = ST_REL;
            ST_REL:         state_next = ST_RELSQ;
            ST_RELSQ:       state_next = ST_RR;
            ST_RR:          state_next = ST_RS;
            ST_RS:          state_next = ST_PY;
            ST_PY:          state_next = ST_ASTEP;
            ST_ASTEP:       state_next = ST_VX;
            ST_VX:          state_next = ST_VY_MUL;
            ST_VY_MUL:      state_next = ST_VY;
            ST_VY: begin
                if (cap_now || vx_reg <= 0 || it_reg == IW'(STEP_LIMIT - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_TOP;
                end
            end
            ST_FIN:         if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // multiplier operands, divider start and handshake
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        s_tready     = (state_reg == ST_IDLE);
        case (state_reg)
            ST_CHECK: begin
                div_start    = !(cap_now || vx_reg == 0);
                div_dividend = 64'(vy_reg) <<< FRAC_BITS;
                div_divisor  = vx_reg;
            end
            ST_BEND_MUL: begin mul_a = 33'(t_reg);     mul_b = 33'(bend_reg);  end
            ST_DXS_MUL:  begin mul_a = 33'(dx_reg);    mul_b = 33'(slope_reg); end
            ST_NXDX:     begin mul_a = 33'(nx_reg);    mul_b = 33'(dx_reg);    end
            ST_NYDY:     begin mul_a = 33'(ny_reg);    mul_b = 33'(dy_reg);    end
            ST_DNORM:    begin mul_a = 33'(ny_reg);    mul_b = 33'(dx_reg);    end
            ST_NXDY:     begin mul_a = 33'(nx_reg);    mul_b = 33'(dy_reg);    end
            ST_DTANG: begin
                mul_a = $signed({2'b00, fric_reg});
                mul_b = 33'(dnorm_reg);
            end
            ST_VXVX:     begin mul_a = 33'(vx_reg);    mul_b = 33'(vx_reg);    end
            ST_VVB:      begin mul_a = 33'(t_reg);     mul_b = 33'(bend_reg);  end
            ST_DXT:      begin mul_a = 33'(dx_reg);    mul_b = 33'(term_reg);  end
            ST_AX_START: begin
                div_start    = 1'b1;
                div_dividend = prod_reg[63:0];
                div_divisor  = denom_reg;
            end
            ST_VSTEP: begin mul_a = 33'(vx_reg); mul_b = $signed({2'b00, step_reg}); end
            ST_RELSQ:    begin mul_a = 33'(t_reg);     mul_b = 33'(t_reg);      end
            ST_RR:       begin mul_a = 33'(t_reg);     mul_b = 33'(slope0_reg); end
            ST_RS:       begin mul_a = 33'(u_reg);     mul_b = 33'(bend_reg);   end
            ST_ASTEP: begin mul_a = 33'(ax_reg); mul_b = $signed({2'b00, step_reg}); end
            ST_VY_MUL:   begin mul_a = 33'(slope_reg); mul_b = 33'(vx_reg);     end
            default: ;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    cpds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .status   (div_st)
    );

    // sequencer state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sx_reg   <= s_tdata[31:0];
                    px_reg   <= s_tdata[31:0];
                    sy_reg   <= s_tdata[63:32];
                    py_reg   <= s_tdata[63:32];
                    vx_reg   <= {1'b0, s_tdata[94:64]};
                    vy_reg   <= s_tdata[126:95];
                    tx_reg   <= s_tdata[158:127];
                    ty_reg   <= s_tdata[190:159];
                    nx_reg   <= s_tdata[222:191];
                    ny_reg   <= s_tdata[254:223];
                    bend_reg <= s_tdata[286:255];
                end
            end
            ST_CHECK: begin
                steps_reg <= '0;
                if (cap_now) begin
                    outcome_reg <= OUT_CAPTURE;
                end else begin
                    outcome_reg <= OUT_UNDERSHOOT;
                end
            end
            ST_SLOPE0_WAIT: begin
                slope0_reg <= div_quot;
                it_reg     <= '0;
            end
            ST_TOP: begin
                dx_reg    <= sat32(64'(px_reg) - 64'(tx_reg));
                dy_reg    <= sat32(64'(py_reg) - 64'(ty_reg));
                t_reg     <= sat32(64'(px_reg) - 64'(sx_reg));
                steps_reg <= it_reg;
                outcome_reg <= OUT_OVERSHOOT;
            end
            ST_SLOPE: slope_reg <= sat32(64'(slope0_reg) + 64'(fm));
            ST_DENOM: denom_reg <= sat32(64'(dy_reg) - 64'(fm));
            ST_NXDX:  outcome_reg <= OUT_UNDERSHOOT;
            ST_NYDY:  t_reg <= fm;
            ST_DNORM: dnorm_reg <= sat32(64'(t_reg) + 64'(fm));
            ST_NXDY:  t_reg <= fm;
            ST_DTANG: dtang_reg <= sat32(64'(t_reg) - 64'(fm));
            ST_FRIC:  outcome_reg <= OUT_SLIP;
            ST_VV:    t_reg <= fm;
            ST_TERM:  term_reg <= sat32(64'($signed({1'b0, grav_reg})) + 64'(fm));
            ST_AX_WAIT: ax_reg <= div_quot;
            ST_PX:    px_reg <= sat32(64'(px_reg) + 64'(fm));
            ST_REL:   t_reg <= sat32(64'(px_reg) - 64'(sx_reg));
            ST_RR:    u_reg <= fm;
            ST_RS:    w_reg <= fm;
            ST_PY:    py_reg <= sat32(64'(sy_reg) + 64'(w_reg) + 64'(fm >>> 1));
            ST_VX:    vx_reg <= sat32(64'(vx_reg) + 64'(fm));
            ST_VY: begin
                vy_reg <= fm;
                if (cap_now) begin
                    outcome_reg <= OUT_CAPTURE;
                end else if (vx_reg <= 0) begin
                    outcome_reg <= OUT_UNDERSHOOT;
                end else if (it_reg == IW'(STEP_LIMIT - 1)) begin
                    outcome_reg <= OUT_LIMIT;
                    steps_reg   <= IW'(STEP_LIMIT);
                end
                it_reg <= it_reg + 1'b1;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_reg <= {3'b000, 10'(steps_reg), vy_reg, vx_reg, py_reg,
                                   px_reg, outcome_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ sv/cpds_checker.sv @@
// port-level checks on the capture point simulator, bound to the top level
module cpds_checker
    import cpds_pkg::*;
#(
    parameter int STEP_LIMIT = 1000
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // a held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // outcome is a known code
    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == OUT_CAPTURE || m_tdata[2:0] == OUT_OVERSHOOT ||
                      m_tdata[2:0] == OUT_UNDERSHOOT || m_tdata[2:0] == OUT_SLIP ||
                      m_tdata[2:0] == OUT_LIMIT))
        else $error("bad outcome code");

    // step limit reports the full count
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == OUT_LIMIT |-> m_tdata[140:131] == 10'(STEP_LIMIT))
        else $error("step limit with wrong count");

endmodule

bind capture_point_dynamics_sim cpds_checker #(.STEP_LIMIT(STEP_LIMIT)) u_cpds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
